// ===== rtl/clebu_pkg.sv =====
package clebu_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = 12;
   localparam int COUNT_W  = 13;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
   localparam logic [ADDR_W-1:0]  TOP_ADDR  = ADDR_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      ACT_LEFT   = 3'd0,
      ACT_RIGHT  = 3'd1,
      ACT_BACK   = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_BOUNDARY = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  char_in;
      logic [11:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [12:0] text_length;
      logic [12:0] cursor_pos;
      logic [1:0]  status;
   } rsp_item_type;

endpackage

// ===== rtl/cursor_line_edit_buffer_unit.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_payload (action, char_in, read_index)
// rsp_      out        rsp_valid / rsp_stall  rsp_payload (char_out, text_length,
//                                                          cursor_pos, status)
//
// Each transaction runs in two steps: the accept cycle issues the one memory
// read, then the execute state writes back, updates the counts and loads the result.
// The single-port-read / single-port-write text memory sets that two-step sequence.
// Reset clears the counts, the sequencer and the result valid; memory needs no clear.
// A stalled result holds the sequencer in its execute state until it drains.
module cursor_line_edit_buffer_unit
   import clebu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload
);

   // Gap buffer: left stack grows up from address 0, right stack grows down
   // from the top address.
   logic [7:0] mem [CAPACITY];

   fsm_type              state_ff, state_in;
   logic [COUNT_W-1:0]   left_ff, left_in;
   logic [COUNT_W-1:0]   right_ff, right_in;
   req_item_type         item_ff;
   logic [7:0]           rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_payload_ff, rsp_payload_in;

   logic                 accept;
   logic                 out_free;
   logic [COUNT_W-1:0]   total;
   logic [ADDR_W-1:0]    gap;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [7:0]           wr_data;
   logic [7:0]           char_out;
   status_type           status;

   assign total    = left_ff + right_ff;
   // Offset from a text index right of the cursor to its right-stack address.
   assign gap      = ADDR_W'(CAP_COUNT - total);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != FSM_IDLE);

   // Read address straight from the incoming transaction.
   always_comb begin
      unique case (req_payload.action)
         ACT_LEFT:  rd_addr = ADDR_W'(left_ff - COUNT_W'(1));
         ACT_RIGHT: rd_addr = ADDR_W'(CAP_COUNT - right_ff);
         default: begin
            if (COUNT_W'(req_payload.read_index) < left_ff) begin
               rd_addr = req_payload.read_index;
            end else begin
               rd_addr = req_payload.read_index + gap;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
         item_ff    <= req_payload;
      end
   end

   // Sequencer and action execution.
   always_comb begin
      state_in       = state_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      wr_en          = 1'b0;
      wr_addr        = left_ff[ADDR_W-1:0];
      wr_data        = item_ff.char_in;
      char_out       = 8'd0;
      status         = ST_DONE;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      unique case (item_ff.action)
         ACT_LEFT: begin
            if (left_ff == '0) begin
               status = ST_BOUNDARY;
            end else begin
               // pop left, push onto right stack
               wr_en    = 1'b1;
               wr_addr  = TOP_ADDR - right_ff[ADDR_W-1:0];
               wr_data  = rd_data_ff;
               left_in  = left_ff - COUNT_W'(1);
               right_in = right_ff + COUNT_W'(1);
            end
         end
         ACT_RIGHT: begin
            if (right_ff == '0) begin
               status = ST_BOUNDARY;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_data_ff;
               left_in  = left_ff + COUNT_W'(1);
               right_in = right_ff - COUNT_W'(1);
            end
         end
         ACT_BACK: begin
            if (left_ff == '0) begin
               status = ST_BOUNDARY;
            end else begin
               left_in = left_ff - COUNT_W'(1);
            end
         end
         ACT_INSERT: begin
            if (total >= CAP_COUNT) begin
               status = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               left_in = left_ff + COUNT_W'(1);
            end
         end
         ACT_READ: begin
            if (COUNT_W'(item_ff.read_index) >= total) begin
               status = ST_RANGE;
            end else begin
               char_out = rd_data_ff;
            end
         end
         default: status = ST_BOUNDARY;
      endcase

      unique case (state_ff)
         FSM_IDLE: begin
            wr_en    = 1'b0;
            left_in  = left_ff;
            right_in = right_ff;
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               // commit: write back, advance counts, load the result
               state_in                   = FSM_IDLE;
               rsp_valid_in               = 1'b1;
               rsp_payload_in.char_out    = char_out;
               rsp_payload_in.text_length = left_in + right_in;
               rsp_payload_in.cursor_pos  = left_in;
               rsp_payload_in.status      = status;
            end else begin
               // hold until the result register drains
               wr_en    = 1'b0;
               left_in  = left_ff;
               right_in = right_ff;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (left_ff + right_ff) <= CAP_COUNT)
      else $error("text length beyond capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == FSM_EXEC))
      else $error("accepted transaction did not enter execute");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == FSM_EXEC))
      else $error("result loaded outside execute");

   a_counts_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |=> ($stable(left_ff) && $stable(right_ff)))
      else $error("counts changed without a committed transaction");

   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.cursor_pos <= rsp_payload_ff.text_length))
      else $error("cursor beyond text length");
`endif

endmodule

// ===== tb/cursor_line_edit_buffer_unit_tb.sv =====
`timescale 1ns / 1ps

module cursor_line_edit_buffer_unit_tb;
   import clebu_pkg::*;

   // Action codes the block does not define; each must come back as a boundary no-op.
   localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [2:0] ACT_SPARE_MID = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

   localparam int DIRECTED_ROWS = 25;

   // One directed row: the edit to send and, where typed is set, the exact response.
   typedef struct packed {
      req_item_type req;
      logic         typed;
      rsp_item_type rsp;
   } edit_row_type;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_payload;

   // Shadow of the line: left stack grows up from 0, right stack down from the top.
   logic [7:0]   line_mem [CAPACITY];
   int unsigned  left_len  = 0;
   int unsigned  right_len = 0;

   rsp_item_type edit_results_q [$];
   int unsigned  error_count = 0;
   int unsigned  action_hits [8];
   int unsigned  status_hits [4];
   int unsigned  edits_checked = 0;
   bit           steady = 1'b0;

   // Directed opening: empty-line corners, undefined codes, the seed string, then moves.
   edit_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{ACT_READ,      8'h00, 12'd0},    1'b1, '{8'h00, 13'd0, 13'd0, ST_RANGE}},
      '{'{ACT_READ,      8'hFF, 12'hFFF},  1'b1, '{8'h00, 13'd0, 13'd0, ST_RANGE}},
      '{'{ACT_LEFT,      8'h00, 12'd0},    1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_RIGHT,     8'h00, 12'd0},    1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_BACK,      8'h00, 12'd0},    1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_SPARE_LO,  8'hFF, 12'hFFF},  1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_SPARE_MID, 8'h55, 12'h555},  1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_SPARE_HI,  8'hAA, 12'hAAA},  1'b1, '{8'h00, 13'd0, 13'd0, ST_BOUNDARY}},
      '{'{ACT_INSERT,    8'h4C, 12'hFFF},  1'b1, '{8'h00, 13'd1, 13'd1, ST_DONE}},
      '{'{ACT_INSERT,    8'h44, 12'd0},    1'b1, '{8'h00, 13'd2, 13'd2, ST_DONE}},
      '{'{ACT_INSERT,    8'h42, 12'd0},    1'b1, '{8'h00, 13'd3, 13'd3, ST_DONE}},
      '{'{ACT_INSERT,    8'h50, 12'd0},    1'b1, '{8'h00, 13'd4, 13'd4, ST_DONE}},
      '{'{ACT_INSERT,    8'h00, 12'd0},    1'b1, '{8'h00, 13'd5, 13'd5, ST_DONE}},
      '{'{ACT_INSERT,    8'hFF, 12'd0},    1'b1, '{8'h00, 13'd6, 13'd6, ST_DONE}},
      '{'{ACT_READ,      8'hFF, 12'd0},    1'b1, '{8'h4C, 13'd6, 13'd6, ST_DONE}},
      '{'{ACT_READ,      8'h00, 12'd5},    1'b1, '{8'hFF, 13'd6, 13'd6, ST_DONE}},
      '{'{ACT_READ,      8'h00, 12'd6},    1'b1, '{8'h00, 13'd6, 13'd6, ST_RANGE}},
      '{'{ACT_LEFT,      8'hFF, 12'hFFF},  1'b0, '0},
      '{'{ACT_LEFT,      8'h00, 12'd0},    1'b0, '0},
      '{'{ACT_READ,      8'h00, 12'd4},    1'b0, '0},
      '{'{ACT_READ,      8'h00, 12'd5},    1'b0, '0},
      '{'{ACT_RIGHT,     8'h00, 12'd0},    1'b0, '0},
      '{'{ACT_BACK,      8'hFF, 12'hFFF},  1'b0, '0},
      '{'{ACT_READ,      8'h00, 12'd4},    1'b0, '0},
      '{'{ACT_INSERT,    8'hA5, 12'hFFF},  1'b0, '0}
   };

   cursor_line_edit_buffer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly back-to-back or short gaps, now and then a long one; none in steady stretches.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (steady)    return 0;
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Apply one edit to the shadow line and return the response it must produce.
   function automatic rsp_item_type apply_edit(input req_item_type item);
      rsp_item_type res;
      logic [7:0]   moved;
      int unsigned  len;
      int unsigned  idx;
      res        = '0;
      res.status = ST_DONE;
      len        = left_len + right_len;
      idx        = item.read_index;
      case (item.action)
         ACT_LEFT: begin
            if (left_len == 0) begin
               res.status = ST_BOUNDARY;
            end else begin
               // pop the left stack, push the character onto the right one
               moved = line_mem[left_len - 1];
               left_len--;
               right_len++;
               line_mem[CAPACITY - right_len] = moved;
            end
         end
         ACT_RIGHT: begin
            if (right_len == 0) begin
               res.status = ST_BOUNDARY;
            end else begin
               moved = line_mem[CAPACITY - right_len];
               right_len--;
               line_mem[left_len] = moved;
               left_len++;
            end
         end
         ACT_BACK: begin
            if (left_len == 0) res.status = ST_BOUNDARY;
            else               left_len--;
         end
         ACT_INSERT: begin
            if (len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               line_mem[left_len] = item.char_in;
               left_len++;
            end
         end
         ACT_READ: begin
            if (idx >= len)          res.status   = ST_RANGE;
            else if (idx < left_len) res.char_out = line_mem[idx];
            else res.char_out = line_mem[CAPACITY - right_len + (idx - left_len)];
         end
         default: res.status = ST_BOUNDARY;
      endcase
      res.text_length = 13'(left_len + right_len);
      res.cursor_pos  = 13'(left_len);
      return res;
   endfunction

   // Random edit; insert_pct sets how hard the line is pushed toward full.
   function automatic req_item_type random_edit(input int unsigned insert_pct);
      req_item_type item;
      int unsigned  pick;
      int unsigned  len;
      pick            = $urandom_range(99);
      len             = left_len + right_len;
      item.char_in    = 8'($urandom);
      item.read_index = 12'($urandom);
      if (pick < insert_pct)           item.action = ACT_INSERT;
      else if (pick < insert_pct + 18) item.action = ACT_BACK;
      else if (pick < insert_pct + 32) item.action = ACT_LEFT;
      else if (pick < insert_pct + 46) item.action = ACT_RIGHT;
      else if (pick < 97)              item.action = ACT_READ;
      else item.action = ACT_SPARE_LO + 3'($urandom_range(0, 2));
      // most reads land inside the text; the rest use the full index range
      if (item.action == ACT_READ && len > 0 && $urandom_range(3) != 0)
         item.read_index = 12'($urandom_range(0, len - 1));
      return item;
   endfunction

   // Present one edit, hold it until accepted, then log the response it owes.
   task automatic issue_edit(input req_item_type item, input logic typed,
                             input rsp_item_type typed_rsp);
      int unsigned  gap;
      rsp_item_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: advance the shadow line
      predicted = apply_edit(item);
      edit_results_q.push_back(typed ? typed_rsp : predicted);
      action_hits[item.action]++;
      status_hits[predicted.status]++;
   endtask

   // Drain side: stall for random stretches, with quiet runs between them.
   initial begin
      int unsigned hold;
      @(negedge reset);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      error_count++;
   endtask

   // Check every response transaction against the oldest outstanding one.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (edit_results_q.size() == 0) begin
            $display("%0t: unexpected response, got %h", $realtime, rsp_payload);
            error_count++;
         end else begin
            want = edit_results_q.pop_front();
            edits_checked++;
            if (rsp_payload.char_out !== want.char_out)
               report_mismatch("char_out", want.char_out, rsp_payload.char_out);
            if (rsp_payload.text_length !== want.text_length)
               report_mismatch("text_length", want.text_length, rsp_payload.text_length);
            if (rsp_payload.cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", want.cursor_pos, rsp_payload.cursor_pos);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", want.status, rsp_payload.status);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table first.
      for (int r = 0; r < DIRECTED_ROWS; r++)
         issue_edit(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].rsp);

      // Short line: random walk with a slight upward drift, so it keeps touching empty.
      for (int n = 0; n < 1000; n++) begin
         steady = (n >= 300 && n < 450);
         issue_edit(random_edit(28), 1'b0, '0);
      end
      steady = 1'b0;

      // Hold the sender until every response has drained.
      req_valid <= 1'b0;
      while (edit_results_q.size() != 0) @(posedge clock);

      // Fill to capacity, parking some text right of the cursor on the way.
      while (left_len + right_len < CAPACITY) begin
         if ($urandom_range(9) == 0)
            issue_edit('{ACT_LEFT, 8'($urandom), 12'($urandom)}, 1'b0, '0);
         else
            issue_edit('{ACT_INSERT, 8'($urandom), 12'($urandom)}, 1'b0, '0);
      end
      repeat (3) issue_edit('{ACT_INSERT, 8'($urandom), 12'($urandom)}, 1'b0, '0);
      issue_edit('{ACT_READ, 8'h00, 12'hFFF}, 1'b0, '0);
      issue_edit('{ACT_READ, 8'hFF, 12'd0}, 1'b0, '0);

      // Near full: inserts dominate, so the full refusal keeps recurring.
      for (int n = 0; n < 1000; n++) begin
         steady = (n >= 600 && n < 700);
         issue_edit(random_edit(40), 1'b0, '0);
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (edit_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("checked %0d edits: %0d left, %0d right, %0d backspace, %0d insert, %0d read",
               edits_checked, action_hits[ACT_LEFT], action_hits[ACT_RIGHT],
               action_hits[ACT_BACK], action_hits[ACT_INSERT], action_hits[ACT_READ]);
      $display("outcomes: %0d done, %0d at boundary, %0d refused full, %0d out of range",
               status_hits[ST_DONE], status_hits[ST_BOUNDARY], status_hits[ST_FULL],
               status_hits[ST_RANGE]);
      if (error_count == 0) begin
         $display("cursor_line_edit_buffer_unit_tb: done, clean");
      end else begin
         $display("cursor_line_edit_buffer_unit_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #25_000_000;
      $display("%0t: timeout with %0d responses outstanding", $realtime,
               edit_results_q.size());
      $display("cursor_line_edit_buffer_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/clebu_pkg.sv
rtl/cursor_line_edit_buffer_unit.sv
tb/cursor_line_edit_buffer_unit_tb.sv
